[rtl/go_back_n_sender_top_assert.svh]
// assertion macros for the go-back-n sender rtl
// expects signals clk and rst in the scope of each use
`ifndef GO_BACK_N_SENDER_TOP_ASSERT_SVH
`define GO_BACK_N_SENDER_TOP_ASSERT_SVH
// condition holds in the same cycle
`define GBN_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// condition holds in the following cycle
`define GBN_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`endif

[rtl/gbn_pkg.sv]
// shared types, constants and the crc byte function of the go-back-n sender
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;
  localparam int MESSAGE_DEPTH = 1024;
  localparam int ADDR_W = $clog2(MESSAGE_DEPTH);
  localparam int LEN_W = ADDR_W + 1;
  localparam int MAX_WINDOW = 8;
  localparam int RESULT_LIMIT = 8;
  localparam int WIN_CAP = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;
  localparam int WIN_W = 4;
  localparam int CRC_BYTES = 6;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam int FLAG_ACK_BIT = 3;
  localparam logic [7:0] FLAG_SYN = 8'h04;
  localparam logic [7:0] FLAG_FIN = 8'h02;
  localparam logic [7:0] FLAG_DATA = 8'h00;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RX = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] KIND_PACKET = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_GAVE_UP = 2'd2;

  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_FIN_WAIT = 2'd2;
  localparam logic [1:0] CFG_FIN_LIMIT = 2'd3;

  typedef enum logic [4:0] {
    PH_LOADING = 5'b00001,
    PH_SYN     = 5'b00010,
    PH_DATA    = 5'b00100,
    PH_FIN     = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic latch;
    logic rx_crc_start;
    logic eval;
    logic fin_enter;
    logic send;
    logic tx_crc_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_is_rx;
    logic crc_done;
    logic ev_emit;
    logic ev_crc;
    logic post_fin;
    logic post_send;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

[rtl/gbn_crc.sv]
// byte-serial crc-32 unit over flag, big-endian sequence and data byte
// depends on gbn_pkg
`timescale 1ns / 1ps
`default_nettype none
module gbn_crc (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] msg,
  output logic             done,
  output logic [31:0]      crc
);
  logic [2:0]  cnt;
  logic [47:0] sh;
  logic [31:0] c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == 3'd1);
      if (start) begin
        cnt <= 3'(gbn_pkg::CRC_BYTES);
      end else if (cnt != 3'd0) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= msg;
      c <= gbn_pkg::CRC_INIT;
    end else if (cnt != 3'd0) begin
      c <= gbn_pkg::crc_byte(c, sh[47:40]);
      sh <= {sh[39:0], 8'h00};
    end
  end

  assign crc = ~c;
endmodule
`default_nettype wire

[rtl/gbn_datapath.sv]
// datapath of the go-back-n sender: input latch, message store, protocol
// registers, pending and output result registers; depends on gbn_pkg, gbn_crc
`timescale 1ns / 1ps
`default_nettype none
`include "go_back_n_sender_top_assert.svh"
module gbn_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gbn_pkg::dp_cmd_t    cmd,
  output gbn_pkg::dp_status_t      status,
  input  wire logic [1:0]          command,
  input  wire logic [7:0]          load_byte,
  input  wire logic                load_final,
  input  wire logic                rx_length_ok,
  input  wire logic [7:0]          rx_flags,
  input  wire logic [31:0]         rx_seq,
  input  wire logic [7:0]          rx_data,
  input  wire logic [31:0]         rx_crc,
  input  wire logic                cfg_valid,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               kind,
  output logic [7:0]               tx_flags,
  output logic [31:0]              tx_seq,
  output logic [7:0]               tx_data,
  output logic [31:0]              tx_crc,
  output logic                     run_last
);
  localparam int LW = gbn_pkg::LEN_W;
  localparam int AW = gbn_pkg::ADDR_W;
  localparam int WW = gbn_pkg::WIN_W;

  // latched request
  logic [1:0]  in_cmd;
  logic [7:0]  ld_byte;
  logic        ld_final;
  logic        len_ok;
  logic [7:0]  rxf;
  logic [31:0] rxs;
  logic [7:0]  rxd;
  logic [31:0] rxc;

  logic [WW-1:0] win_cfg;
  logic [7:0]    timeout_cfg;
  logic [7:0]    fin_wait_cfg;
  logic [5:0]    fin_limit_cfg;

  gbn_pkg::phase_t phase;
  logic [LW-1:0]   msg_len;
  logic [31:0]     acked;
  logic [LW-1:0]   sent;
  logic [7:0]      wait_timer;
  logic [5:0]      fin_att;
  logic [3:0]      n_sent;

  logic [7:0] store [gbn_pkg::MESSAGE_DEPTH];
  logic [7:0] rd_data;

  logic [1:0]  pend_kind;
  logic [7:0]  pend_flags;
  logic [31:0] pend_seq;
  logic [7:0]  pend_data;
  logic        pend_last;
  logic        pend_crc;

  logic        crc_done;
  logic [31:0] crc_val;
  logic [47:0] crc_msg;

  logic          active, eff_loading, rx_ok, give_up, ev_closed;
  logic [7:0]    timer_inc;
  logic [5:0]    att_inc;
  logic [LW-1:0] len_base;
  logic [WW-1:0] w_eff;
  logic [LW:0]   win_sum, wmax;
  logic          send_last;

  assign crc_msg = cmd.rx_crc_start ? {rxf, rxs, rxd} : {pend_flags, pend_seq, pend_data};

  gbn_crc u_crc (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.rx_crc_start | cmd.tx_crc_start),
    .msg   (crc_msg),
    .done  (crc_done),
    .crc   (crc_val)
  );

  always_comb begin
    active = (phase == gbn_pkg::PH_SYN) || (phase == gbn_pkg::PH_DATA);
    eff_loading = (phase == gbn_pkg::PH_LOADING) || (phase == gbn_pkg::PH_DONE);
    len_base = (phase == gbn_pkg::PH_DONE) ? '0 : msg_len;
    rx_ok = len_ok && (rxc == crc_val);
    timer_inc = (wait_timer == 8'hFF) ? 8'hFF : wait_timer + 8'd1;
    att_inc = (fin_att == 6'h3F) ? 6'h3F : fin_att + 6'd1;
    give_up = fin_att >= fin_limit_cfg;
    ev_closed = (phase == gbn_pkg::PH_FIN) && (in_cmd == gbn_pkg::CMD_RX) && rx_ok;
    if (win_cfg == '0) begin
      w_eff = WW'(1);
    end else if (win_cfg > WW'(gbn_pkg::WIN_CAP)) begin
      w_eff = WW'(gbn_pkg::WIN_CAP);
    end else begin
      w_eff = win_cfg;
    end
    win_sum = {1'b0, acked[LW-1:0]} + (LW+1)'(w_eff);
    if (phase == gbn_pkg::PH_SYN) begin
      wmax = (LW+1)'(1);
    end else if (win_sum > {1'b0, msg_len}) begin
      wmax = {1'b0, msg_len};
    end else begin
      wmax = win_sum;
    end
    // a request ends its run at the window edge or at the result limit
    send_last = (({1'b0, sent} + (LW+1)'(1)) >= wmax) ||
                (n_sent == 4'(gbn_pkg::RESULT_LIMIT - 1));

    status.cmd_is_rx = (in_cmd == gbn_pkg::CMD_RX);
    status.crc_done = crc_done;
    status.ev_emit = (phase == gbn_pkg::PH_FIN) && ((in_cmd == gbn_pkg::CMD_RX) ||
                     ((in_cmd == gbn_pkg::CMD_TICK) && (timer_inc >= fin_wait_cfg)));
    status.ev_crc = status.ev_emit && !ev_closed && !give_up;
    status.post_fin = active && (acked >= 32'(msg_len));
    status.post_send = active && !status.post_fin && ({1'b0, sent} < wmax) &&
                       (n_sent < 4'(gbn_pkg::RESULT_LIMIT));
    status.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_cmd <= command;
      ld_byte <= load_byte;
      ld_final <= load_final;
      len_ok <= rx_length_ok;
      rxf <= rx_flags;
      rxs <= rx_seq;
      rxd <= rx_data;
      rxc <= rx_crc;
    end
  end

  // message store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.eval && (in_cmd == gbn_pkg::CMD_LOAD) && eff_loading &&
        (len_base < LW'(gbn_pkg::MESSAGE_DEPTH))) begin
      store[len_base[AW-1:0]] <= ld_byte;
    end
    rd_data <= store[sent[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg <= WW'(5);
      timeout_cfg <= 8'd10;
      fin_wait_cfg <= 8'd5;
      fin_limit_cfg <= 6'd25;
      phase <= gbn_pkg::PH_LOADING;
      msg_len <= '0;
      acked <= '0;
      sent <= '0;
      wait_timer <= '0;
      fin_att <= '0;
      n_sent <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          gbn_pkg::CFG_WINDOW:    win_cfg <= cfg_data[WW-1:0];
          gbn_pkg::CFG_TIMEOUT:   timeout_cfg <= cfg_data;
          gbn_pkg::CFG_FIN_WAIT:  fin_wait_cfg <= cfg_data;
          gbn_pkg::CFG_FIN_LIMIT: fin_limit_cfg <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        case (in_cmd)
          gbn_pkg::CMD_LOAD: begin
            if (eff_loading) begin
              if (len_base < LW'(gbn_pkg::MESSAGE_DEPTH)) begin
                msg_len <= len_base + LW'(1);
              end else begin
                msg_len <= len_base;
              end
              acked <= '0;
              sent <= '0;
              wait_timer <= '0;
              fin_att <= '0;
              phase <= ld_final ? gbn_pkg::PH_SYN : gbn_pkg::PH_LOADING;
            end
          end
          gbn_pkg::CMD_RX: begin
            if (active) begin
              if (rx_ok && rxf[gbn_pkg::FLAG_ACK_BIT]) begin
                if (rxs > acked) begin
                  acked <= rxs;
                  wait_timer <= '0;
                end else if (rxs == 32'd0) begin
                  phase <= gbn_pkg::PH_DATA;
                  sent <= '0;
                end
              end
            end else if (phase == gbn_pkg::PH_FIN) begin
              if (rx_ok || give_up) begin
                phase <= gbn_pkg::PH_DONE;
              end else begin
                fin_att <= att_inc;
                wait_timer <= '0;
              end
            end
          end
          gbn_pkg::CMD_TICK: begin
            if (active) begin
              if (timer_inc >= timeout_cfg) begin
                sent <= acked[LW-1:0];
                wait_timer <= '0;
              end else begin
                wait_timer <= timer_inc;
              end
            end else if (phase == gbn_pkg::PH_FIN) begin
              if (timer_inc >= fin_wait_cfg) begin
                if (give_up) begin
                  phase <= gbn_pkg::PH_DONE;
                  wait_timer <= timer_inc;
                end else begin
                  fin_att <= att_inc;
                  wait_timer <= '0;
                end
              end else begin
                wait_timer <= timer_inc;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.fin_enter) begin
        phase <= gbn_pkg::PH_FIN;
        fin_att <= 6'd1;
        wait_timer <= '0;
      end
      if (cmd.send) begin
        sent <= sent + LW'(1);
      end
      // packets sent for the current request
      if (cmd.latch) begin
        n_sent <= '0;
      end else if (cmd.send) begin
        n_sent <= n_sent + 4'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending result, filled before its crc runs
  always_ff @(posedge clk) begin
    if (cmd.eval && status.ev_emit) begin
      pend_last <= 1'b1;
      pend_data <= '0;
      if (ev_closed || give_up) begin
        pend_kind <= ev_closed ? gbn_pkg::KIND_CLOSED : gbn_pkg::KIND_GAVE_UP;
        pend_flags <= '0;
        pend_seq <= '0;
        pend_crc <= 1'b0;
      end else begin
        pend_kind <= gbn_pkg::KIND_PACKET;
        pend_flags <= gbn_pkg::FLAG_FIN;
        pend_seq <= acked + 32'd1;
        pend_crc <= 1'b1;
      end
    end else if (cmd.fin_enter) begin
      pend_kind <= gbn_pkg::KIND_PACKET;
      pend_flags <= gbn_pkg::FLAG_FIN;
      pend_seq <= acked + 32'd1;
      pend_data <= '0;
      pend_last <= 1'b1;
      pend_crc <= 1'b1;
    end else if (cmd.send) begin
      pend_kind <= gbn_pkg::KIND_PACKET;
      pend_last <= send_last;
      pend_crc <= 1'b1;
      if (phase == gbn_pkg::PH_SYN) begin
        pend_flags <= gbn_pkg::FLAG_SYN;
        pend_seq <= '0;
        pend_data <= '0;
      end else begin
        pend_flags <= gbn_pkg::FLAG_DATA;
        pend_seq <= 32'(sent) + 32'd1;
        pend_data <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind <= pend_kind;
      tx_flags <= pend_flags;
      tx_seq <= pend_seq;
      tx_data <= pend_data;
      tx_crc <= pend_crc ? crc_val : 32'd0;
      run_last <= pend_last;
    end
  end

  `GBN_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `GBN_ASSERT_NOW(a_send_allowed, cmd.send, status.post_send, "packet sent outside window")
  `GBN_ASSERT_NEXT(a_fin_counted, cmd.fin_enter, fin_att != 6'd0, "fin sent but not counted")
endmodule
`default_nettype wire

[rtl/gbn_ctrl.sv]
// controller state machine of the go-back-n sender
// depends on gbn_pkg; drives gbn_datapath through command and status structs
`timescale 1ns / 1ps
`default_nettype none
module gbn_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gbn_pkg::dp_status_t status,
  output gbn_pkg::dp_cmd_t         cmd
);
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_RXCRC    = 9'b000000100,
    S_EVAL     = 9'b000001000,
    S_POST     = 9'b000010000,
    S_READ     = 9'b000100000,
    S_CSTART   = 9'b001000000,
    S_CWAIT    = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.cmd_is_rx) begin
          cmd.rx_crc_start = 1'b1;
          state_next = S_RXCRC;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_RXCRC: begin
        if (status.crc_done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.ev_emit) begin
          state_next = status.ev_crc ? S_CSTART : S_OUT;
        end else begin
          state_next = S_POST;
        end
      end
      S_POST: begin
        if (status.post_fin) begin
          cmd.fin_enter = 1'b1;
          state_next = S_CSTART;
        end else if (status.post_send) begin
          state_next = S_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.send = 1'b1;
        state_next = S_CSTART;
      end
      S_CSTART: begin
        cmd.tx_crc_start = 1'b1;
        state_next = S_CWAIT;
      end
      S_CWAIT: begin
        if (status.crc_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_POST;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/go_back_n_sender_top.sv]
// channel  | handshake            | payload
// in       | in_valid / in_ready  | command, load_byte, load_final, rx_* fields
// out      | out_valid / out_ready| kind, tx_flags, tx_seq, tx_data, tx_crc, run_last
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
// a load or tick with no result passes dispatch, eval and post; a received packet also
// has its crc checked; a packet goes through window check, store read (syn, data),
// crc start, the byte-serial crc unit and output load; at most 8 results per request
// an item is taken only when the controller is idle; a waiting result is held in the
// output register and stalls the next result, not the next request
// synchronous reset; the message store is not cleared, only its fill count
// top level of the go-back-n sender; depends on gbn_pkg, gbn_ctrl, gbn_datapath
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_sender_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  load_byte,
  input  wire logic        load_final,
  input  wire logic        rx_length_ok,
  input  wire logic [7:0]  rx_flags,
  input  wire logic [31:0] rx_seq,
  input  wire logic [7:0]  rx_data,
  input  wire logic [31:0] rx_crc,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       tx_flags,
  output logic [31:0]      tx_seq,
  output logic [7:0]       tx_data,
  output logic [31:0]      tx_crc,
  output logic             run_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  gbn_pkg::dp_cmd_t    cmd;
  gbn_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .command      (command),
    .load_byte    (load_byte),
    .load_final   (load_final),
    .rx_length_ok (rx_length_ok),
    .rx_flags     (rx_flags),
    .rx_seq       (rx_seq),
    .rx_data      (rx_data),
    .rx_crc       (rx_crc),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .tx_flags     (tx_flags),
    .tx_seq       (tx_seq),
    .tx_data      (tx_data),
    .tx_crc       (tx_crc),
    .run_last     (run_last)
  );
endmodule
`default_nettype wire
